### sv/bdq_pkg.sv
// Package for the bounded double-ended queue with delete by value.
// Holds the command and status codes and the transaction payload types.
// Depends on nothing; the top level and the testbench import it.
package bdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_READ_OUT   = 3'd5,
    CMD_SPARE_6    = 3'd6,
    CMD_SPARE_7    = 3'd7
  } bdq_cmd_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } bdq_out_t;

endpackage

### sv/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bounded_deque_with_delete_match.sv
// Top level of the bounded double-ended queue with delete by value.
// Depends on bdq_pkg for codes and payload types and on bdq_ram for the entry store.
//
//   Channel | Ports                          | Payload
//   input   | in_valid, in_stall, in_data    | bdq_in_t: command, value
//   result  | out_valid, out_stall, out_data | bdq_out_t: status, element, last
//
// Push, pop and unused commands complete at acceptance, when the result register is loaded.
// Delete by value reads each entry from the head in S_SCAN_RD and compares it in S_SCAN_CHK;
// on a match it moves every later entry one place toward the head through S_SHIFT_RD and
// S_SHIFT_WR, since one RAM read port serves both the search and the closing of the gap.
// Read out sends each entry through the registered RAM read and the result register.
// Reset clears the head pointer and the count; no clearing pass over the store is needed.
// A new transaction is taken only when the sequencer is idle and the result register is free.
module bounded_deque_with_delete_match
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bdq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bdq_out_t out_data
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CAP_W   = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_PH = PW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_READ_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [PW-1:0]            ptr_r, ptr_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bdq_out_t                 out_data_r, out_data_nxt;

  logic                     we;
  logic [PW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [PW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;

  logic                     out_free;
  logic                     in_take;
  logic [CW:0]              tail_sum;
  logic [PW-1:0]            tail_ph;
  logic [PW-1:0]            head_inc;
  logic [PW-1:0]            head_dec;
  logic [PW-1:0]            ptr_inc;
  logic [CW-1:0]            idx_inc;
  logic [CW-1:0]            idx_inc2;
  logic                     full;
  logic                     empty;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_take  = in_valid && !in_stall;

  assign tail_sum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail_ph  = (tail_sum >= CAP_W) ? PW'(tail_sum - CAP_W) : PW'(tail_sum);
  assign head_inc = (head_r == LAST_PH) ? '0 : head_r + PW'(1);
  assign head_dec = (head_r == '0) ? LAST_PH : head_r - PW'(1);
  assign ptr_inc  = (ptr_r == LAST_PH) ? '0 : ptr_r + PW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_inc2 = idx_r + CW'(2);
  assign full     = (count_r == CAP_C);
  assign empty    = (count_r == '0);

  assign raddr = (state_r == S_SHIFT_RD) ? ptr_inc : ptr_r;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = ptr_r;
    wdata         = rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = ST_OK;
          out_data_nxt.element = '0;
          out_data_nxt.last    = 1'b1;
          val_nxt              = in_data.value;
          ptr_nxt              = head_r;
          idx_nxt              = '0;
          unique case (bdq_cmd_t'(in_data.command))
            CMD_PUSH_FRONT: begin
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = head_dec;
                wdata     = in_data.value;
                head_nxt  = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = tail_ph;
                wdata     = in_data.value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN_RD;
              end
            end
            CMD_READ_OUT: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ_RD;
              end
            end
            CMD_SPARE_6, CMD_SPARE_7: begin
              out_data_nxt.status = ST_OK;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (rdata == val_r) begin
          if (idx_inc == count_r) begin
            count_nxt            = count_r - CW'(1);
            out_valid_nxt        = 1'b1;
            out_data_nxt.status  = ST_OK;
            out_data_nxt.element = '0;
            out_data_nxt.last    = 1'b1;
            state_nxt            = S_IDLE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else if (idx_inc == count_r) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = ST_NOTFOUND;
          out_data_nxt.element = '0;
          out_data_nxt.last    = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          ptr_nxt   = ptr_inc;
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = ptr_r;
        wdata   = rdata;
        ptr_nxt = ptr_inc;
        idx_nxt = idx_inc;
        if (idx_inc2 == count_r) begin
          count_nxt            = count_r - CW'(1);
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = ST_OK;
          out_data_nxt.element = '0;
          out_data_nxt.last    = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end

      S_READ_RD: begin
        if (out_free) begin
          state_nxt = S_READ_OUT;
        end
      end

      S_READ_OUT: begin
        out_valid_nxt        = 1'b1;
        out_data_nxt.status  = ST_OK;
        out_data_nxt.element = rdata;
        out_data_nxt.last    = (idx_inc == count_r);
        if (idx_inc == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_inc;
          idx_nxt   = idx_inc;
          state_nxt = S_READ_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque_with_delete_match: a scoreboard class keeps
// its own copy of the list and checks every result transaction field by field.
// Depends on bdq_pkg for the command and status codes and the payload types.
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH         = 32;
  localparam int RANDOM_ITEMS  = 138;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 150;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] stored_values[$];
    bdq_out_t                 expected_results[$];
    int                       capacity;
    int                       error_count;

    function new(int cap);
      capacity    = cap;
      error_count = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    function void queue_result(logic [1:0] status, logic signed [DATA_W-1:0] element,
                               logic last);
      bdq_out_t r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      expected_results.push_back(r);
    endfunction

    function void note_command(bdq_in_t item);
      bdq_cmd_t cmd;
      int       pos;
      cmd = bdq_cmd_t'(item.command);
      pos = -1;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (stored_values.size() >= capacity) begin
            queue_result(ST_FULL, '0, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) stored_values.push_front(item.value);
            else stored_values.push_back(item.value);
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (stored_values.size() == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) void'(stored_values.pop_front());
            else void'(stored_values.pop_back());
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        CMD_DELETE: begin
          if (stored_values.size() == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (stored_values[i]) begin
              if (pos < 0 && stored_values[i] == item.value) pos = i;
            end
            if (pos >= 0) begin
              stored_values.delete(pos);
              queue_result(ST_OK, '0, 1'b1);
            end else begin
              queue_result(ST_NOTFOUND, '0, 1'b1);
            end
          end
        end
        CMD_READ_OUT: begin
          if (stored_values.size() == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (stored_values[i]) begin
              queue_result(ST_OK, stored_values[i], i == stored_values.size() - 1);
            end
          end
        end
        default: queue_result(ST_OK, '0, 1'b1);
      endcase
    endfunction

    task check_result(bdq_out_t got);
      bdq_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d element %0d last %0b",
                                  got.status, got.element, got.last));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.element !== want.element)
          report_mismatch($sformatf("element %0d, expected %0d", got.element, want.element));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask

    function logic signed [DATA_W-1:0] pick_stored();
      return stored_values[$urandom_range(stored_values.size() - 1)];
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  bdq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bdq_out_t out_data;
  logic     calm      = 1'b0;
  int       stuck_cycles = 0;

  deque_scoreboard sb;

  bounded_deque_with_delete_match #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic bdq_in_t make_item(bdq_cmd_t cmd, logic [DATA_W-1:0] val);
    bdq_in_t item;
    item.command = cmd;
    item.value   = val;
    return item;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic drive_command(input bdq_in_t item);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 30) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(item);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL bounded_deque_with_delete_match");
      $finish;
    end
  end

  initial begin
    bdq_in_t  item;
    bdq_cmd_t cmd;
    int       filling;
    int       r;
    int       n;
    sb = new(DEPTH);
    filling = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    drive_command(make_item(CMD_READ_OUT, '0));
    drive_command(make_item(CMD_POP_FRONT, '1));
    drive_command(make_item(CMD_POP_BACK, '0));
    drive_command(make_item(CMD_DELETE, '0));
    drive_command(make_item(CMD_SPARE_6, '1));
    drive_command(make_item(CMD_SPARE_7, 32'h8000_0000));
    drive_command(make_item(CMD_PUSH_FRONT, 32'h8000_0000));
    drive_command(make_item(CMD_PUSH_BACK, 32'h7fff_ffff));
    drive_command(make_item(CMD_PUSH_FRONT, '1));
    drive_command(make_item(CMD_PUSH_BACK, '0));
    drive_command(make_item(CMD_PUSH_BACK, 32'h7fff_ffff));
    drive_command(make_item(CMD_READ_OUT, '1));
    drive_command(make_item(CMD_DELETE, 32'h7fff_ffff));
    drive_command(make_item(CMD_DELETE, 32'hffff_fffe));
    drive_command(make_item(CMD_DELETE, 32'h1234_5678));
    drive_command(make_item(CMD_SPARE_6, 32'h5555_5555));
    drive_command(make_item(CMD_READ_OUT, 32'haaaa_aaaa));
    drive_command(make_item(CMD_POP_FRONT, '0));
    drive_command(make_item(CMD_POP_BACK, '0));
    drive_command(make_item(CMD_READ_OUT, '0));
    drive_command(make_item(CMD_DELETE, '1));
    drive_command(make_item(CMD_READ_OUT, '0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 70 && n < 110);
      if (sb.stored_values.size() == DEPTH && $urandom_range(3) == 0) filling = 0;
      else if (sb.stored_values.size() == 0 && $urandom_range(2) == 0) filling = 1;
      r = $urandom_range(99);
      if (filling)
        cmd = r < 35 ? CMD_PUSH_BACK : r < 70 ? CMD_PUSH_FRONT : r < 78 ? CMD_POP_FRONT :
              r < 84 ? CMD_POP_BACK : r < 90 ? CMD_DELETE : r < 97 ? CMD_READ_OUT :
              r < 99 ? CMD_SPARE_6 : CMD_SPARE_7;
      else
        cmd = r < 10 ? CMD_PUSH_BACK : r < 20 ? CMD_PUSH_FRONT : r < 45 ? CMD_POP_FRONT :
              r < 68 ? CMD_POP_BACK : r < 88 ? CMD_DELETE : r < 97 ? CMD_READ_OUT :
              r < 99 ? CMD_SPARE_6 : CMD_SPARE_7;
      item = make_item(cmd, random_value());
      if (cmd == CMD_DELETE && sb.stored_values.size() > 0 && $urandom_range(9) < 7)
        item.value = sb.pick_stored();
      drive_command(item);
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("PASS bounded_deque_with_delete_match");
    end else begin
      $display("FAIL bounded_deque_with_delete_match");
    end
    $finish;
  end
endmodule

### files.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bounded_deque_with_delete_match.sv
tb/tb_top.sv
